/* src/eroi_pkg.sv */
// eroi_pkg: shared types, constants and fixed point helpers for the
// reed oscillator integrator. Depends on nothing; every other file imports it.
`default_nettype none

package eroi_pkg;

	// number of Euler steps per item and fraction bits of the fixed point format
	localparam int STEPS     = 1000;
	localparam int FRAC_BITS = 20;

	// queue between front and engine
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// configuration register map
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CUBIC_GAIN  = CFG_IDX_W'(1);
	localparam logic signed [31:0] LINEAR_GAIN_RST = 32'sd5242880;
	localparam logic signed [31:0] CUBIC_GAIN_RST  = 32'sd4194304;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] start_position;
		logic signed [31:0] start_velocity;
		logic        [30:0] time_span;
		logic signed [31:0] stiffness;
	} item_t;

	typedef struct packed {
		logic signed [31:0] end_position;
		logic signed [31:0] end_velocity;
		logic               overflow;
	} result_t;

	// work entry handed from front to engine
	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic        [30:0] dt;
		logic signed [31:0] stiffness;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic idle;
		logic last_update;
	} eng_status_t;

	// saturated value plus clamp flag
	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} qres_t;

	function automatic qres_t clamp64(logic signed [63:0] v);
		qres_t r;
		if (v > SAT_MAX) begin
			r.val = 32'sh7fffffff;
			r.sat = 1'b1;
		end else if (v < SAT_MIN) begin
			r.val = 32'sh80000000;
			r.sat = 1'b1;
		end else begin
			r.val = v[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// product shifted down with floor rounding, then saturated
	function automatic qres_t qmul(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] aw;
		logic signed [63:0] bw;
		logic signed [63:0] p;
		aw = {{32{a[31]}}, a};
		bw = {{32{b[31]}}, b};
		p  = aw * bw;
		return clamp64(p >>> FRAC_BITS);
	endfunction

	function automatic qres_t qadd(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] s;
		s = {{32{a[31]}}, a} + {{32{b[31]}}, b};
		return clamp64(s);
	endfunction

	function automatic qres_t qsub(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] s;
		s = {{32{a[31]}}, a} - {{32{b[31]}}, b};
		return clamp64(s);
	endfunction

endpackage

`default_nettype wire

/* src/eroi_front.sv */
// eroi_front: accepts items and turns the time span into the step size.
// Depends on eroi_pkg; feeds eroi_queue.
`default_nettype none

module eroi_front (
	input  wire logic               start,
	output logic                    busy,
	input  wire eroi_pkg::item_t    item,
	input  wire eroi_pkg::q_status_t q_status,
	output logic                    push,
	output eroi_pkg::work_t         push_entry
);
	import eroi_pkg::*;

	// floor(span / STEPS) as a multiply by a rounded-up reciprocal
	localparam int DIV_SH = 31 + $clog2(STEPS);
	localparam logic [64:0] DIV_ONE = 65'd1 << DIV_SH;
	localparam logic [32:0] DIV_M = 33'((DIV_ONE + 65'(STEPS) - 65'd1) / 65'(STEPS));

	logic [63:0] span_prod;

	// accept whenever the queue has room
	assign busy = q_status.full;
	assign push = start && !q_status.full;

	// step size
	assign span_prod = 64'(item.time_span) * 64'(DIV_M);

	always_comb begin
		push_entry.position  = item.start_position;
		push_entry.velocity  = item.start_velocity;
		push_entry.dt        = 31'(span_prod >> DIV_SH);
		push_entry.stiffness = item.stiffness;
	end

endmodule

`default_nettype wire

/* src/eroi_queue.sv */
// eroi_queue: short item queue between the front and the integration engine.
// Depends on eroi_pkg.
`default_nettype none

module eroi_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire eroi_pkg::work_t     push_entry,
	input  wire logic                pop,
	output eroi_pkg::work_t          head,
	output eroi_pkg::q_status_t      q_status
);
	import eroi_pkg::*;

	work_t              entries_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign q_status.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_status.empty = (count_q == '0);
	assign do_push = push && !q_status.full;
	assign do_pop  = pop && !q_status.empty;
	assign head    = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/eroi_engine.sv */
// eroi_engine: runs the forward Euler steps of one item at a time, in a
// chain of phases a step, and presents the result. Depends on eroi_pkg.
`default_nettype none

module eroi_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic signed [31:0]  linear_gain,
	input  wire logic signed [31:0]  cubic_gain,
	input  wire eroi_pkg::work_t     head,
	input  wire eroi_pkg::q_status_t q_status,
	output logic                     pop,
	output logic                     done,
	output eroi_pkg::result_t        result,
	output eroi_pkg::eng_status_t    eng_status
);
	import eroi_pkg::*;

	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PROD  = 7'b0000010,
		ST_CUBE  = 7'b0000100,
		ST_CGAIN = 7'b0001000,
		ST_ACC   = 7'b0010000,
		ST_DV    = 7'b0100000,
		ST_UPD   = 7'b1000000
	} eng_state_t;

	eng_state_t         state_q;
	logic [STEP_W-1:0]  step_q;
	logic signed [31:0] x_q, v_q, k_q;
	logic        [30:0] dt_q;
	logic signed [31:0] s_q, p_q, r_q, dx_q, c_q, bq_q, acc_q, dv_q;
	logic               sat_q;
	logic               done_q;
	result_t            result_q;
	logic               last_step;
	logic signed [31:0] dt_s;

	qres_t m_s, m_p, m_r, m_dx, m_c, m_bq, d_pq, d_acc, m_dv, a_x, a_v;

	assign dt_s      = {1'b0, dt_q};
	assign last_step = (step_q == STEP_W'(STEPS - 1));
	assign pop       = (state_q == ST_IDLE) && !q_status.empty;

	// arithmetic of each phase
	always_comb begin
		m_s   = qmul(v_q, v_q);
		m_p   = qmul(linear_gain, v_q);
		m_r   = qmul(k_q, x_q);
		m_dx  = qmul(dt_s, v_q);
		m_c   = qmul(s_q, v_q);
		m_bq  = qmul(cubic_gain, c_q);
		d_pq  = qsub(p_q, bq_q);
		d_acc = qsub(d_pq.val, r_q);
		m_dv  = qmul(dt_s, acc_q);
		a_x   = qadd(x_q, dx_q);
		a_v   = qadd(v_q, dv_q);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q   <= head.position;
				v_q   <= head.velocity;
				dt_q  <= head.dt;
				k_q   <= head.stiffness;
				sat_q <= 1'b0;
			end
			ST_PROD: begin
				s_q   <= m_s.val;
				p_q   <= m_p.val;
				r_q   <= m_r.val;
				dx_q  <= m_dx.val;
				sat_q <= sat_q | m_s.sat | m_p.sat | m_r.sat | m_dx.sat;
			end
			ST_CUBE: begin
				c_q   <= m_c.val;
				x_q   <= a_x.val;
				sat_q <= sat_q | m_c.sat | a_x.sat;
			end
			ST_CGAIN: begin
				bq_q  <= m_bq.val;
				sat_q <= sat_q | m_bq.sat;
			end
			ST_ACC: begin
				acc_q <= d_acc.val;
				sat_q <= sat_q | d_pq.sat | d_acc.sat;
			end
			ST_DV: begin
				dv_q  <= m_dv.val;
				sat_q <= sat_q | m_dv.sat;
			end
			ST_UPD: begin
				v_q   <= a_v.val;
				sat_q <= sat_q | a_v.sat;
				result_q.end_position <= x_q;
				result_q.end_velocity <= a_v.val;
				result_q.overflow     <= sat_q | a_v.sat;
			end
			default: begin
			end
		endcase
	end

	// phase sequencer and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (!q_status.empty) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD:  state_q <= ST_CUBE;
				ST_CUBE:  state_q <= ST_CGAIN;
				ST_CGAIN: state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_DV;
				ST_DV:    state_q <= ST_UPD;
				ST_UPD: begin
					if (last_step) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_PROD;
						step_q  <= step_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;
	assign eng_status.idle        = (state_q == ST_IDLE);
	assign eng_status.last_update = (state_q == ST_UPD) && last_step;

endmodule

`default_nettype wire

/* src/euler_reed_oscillator_integrator_unit.sv */
// euler_reed_oscillator_integrator_unit: top level of the reed oscillator
// integrator. Depends on eroi_pkg, eroi_front, eroi_queue and eroi_engine.
//
// Usage:
//   An item (start position, velocity, time span, stiffness) is taken at a
//   rising edge with start high and busy low. The front works out the step
//   size span/STEPS and places the item in a two-entry queue, so up to two
//   items can wait while the engine integrates another.
//   The engine runs STEPS forward Euler steps, each through the chain
//   square, cube, cubic gain, subtract, step product, add of the shared
//   step datapath, after loading the item from the queue; it takes the
//   next queued item once it is back in idle.
//   Each result shows on result for one cycle with done high; the receiver
//   cannot stall it, and none is held back.
//   Gains are written on the cfg channel (index 0 linear, 1 cubic, others
//   ignored); cfg_ready is always high. Write them only while idle.
//   Reset clears the queue and sequencer and loads gains 5.0 and 4.0.
`default_nettype none

module euler_reed_oscillator_integrator_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire eroi_pkg::item_t                   item,
	output logic                                   done,
	output eroi_pkg::result_t                      result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [eroi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [31:0]                       cfg_data
);
	import eroi_pkg::*;

	logic signed [31:0] linear_gain_q;
	logic signed [31:0] cubic_gain_q;
	q_status_t          q_status;
	eng_status_t        eng_status;
	logic               push;
	logic               pop;
	work_t              push_entry;
	work_t              head;

	assign cfg_ready = 1'b1;

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linear_gain_q <= LINEAR_GAIN_RST;
			cubic_gain_q  <= CUBIC_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LINEAR_GAIN: linear_gain_q <= cfg_data;
				REG_CUBIC_GAIN:  cubic_gain_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	eroi_front u_front (
		.start      (start),
		.busy       (busy),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	eroi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	eroi_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.linear_gain (linear_gain_q),
		.cubic_gain  (cubic_gain_q),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.done        (done),
		.result      (result),
		.eng_status  (eng_status)
	);

	// queue is never both full and empty
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue reports full and empty");

	// a result follows only the last update of an item
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		eng_status.last_update |=> done)
		else $error("missing result after last step");

	// results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// a result strobe always leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> eng_status.idle)
		else $error("result shown while engine still busy");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// tb_top: self-checking bench for the reed oscillator integrator unit.
// Needs eroi_pkg and euler_reed_oscillator_integrator_unit; predicts each
// end point with its own fixed point Euler loop and checks every result.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import eroi_pkg::*;

	localparam int N_STEPS = 1000;
	localparam int Q_FRAC = 20;
	localparam int Q_ONE = 1 << Q_FRAC;
	localparam int ITEM_LATENCY = 6 * N_STEPS + 2;
	localparam int LONG_GAP = ITEM_LATENCY + 16;
	localparam int TOTAL_ITEMS = 650;
	localparam longint CYCLE_LIMIT = 64'(TOTAL_ITEMS) * (2 * ITEM_LATENCY + LONG_GAP) * 3;
	localparam int REPORT_LIMIT = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = '1;
	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// gains as the bench believes the block holds them
	logic signed [31:0] linear_gain_model;
	logic signed [31:0] cubic_gain_model;

	result_t pending_endpoints[$];
	int mismatch_count;
	longint cycle_count;

	euler_reed_oscillator_integrator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// saturate a wide value to 32 bits, noting any clamp
	function automatic logic signed [31:0] fx_clamp(input logic signed [63:0] v,
			inout bit clipped);
		if (v > 64'sd2147483647) begin
			clipped = 1'b1;
			return Q_MAX;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1'b1;
			return Q_MIN;
		end
		return v[31:0];
	endfunction

	// fixed point product, floor rounding by arithmetic shift
	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
			input logic signed [31:0] b, inout bit clipped);
		logic signed [63:0] prod;
		prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
		return fx_clamp(prod >>> Q_FRAC, clipped);
	endfunction

	function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
			input logic signed [31:0] b, inout bit clipped);
		return fx_clamp($signed({{32{a[31]}}, a}) + $signed({{32{b[31]}}, b}), clipped);
	endfunction

	function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
			input logic signed [31:0] b, inout bit clipped);
		return fx_clamp($signed({{32{a[31]}}, a}) - $signed({{32{b[31]}}, b}), clipped);
	endfunction

	// forward Euler over the whole span, both derivatives from the old state
	function automatic result_t integrate_reed(input item_t it,
			input logic signed [31:0] a_gain, input logic signed [31:0] b_gain);
		logic signed [31:0] pos, vel, dt, sq, cube, lin_term, cub_term;
		logic signed [31:0] spring, lin_less_cub, accel, dx, dv;
		logic [31:0] span_w;
		bit clipped;
		result_t res;
		pos = it.start_position;
		vel = it.start_velocity;
		span_w = {1'b0, it.time_span};
		dt = span_w / N_STEPS;
		clipped = 1'b0;
		for (int n = 0; n < N_STEPS; n++) begin
			sq = fx_mul(vel, vel, clipped);
			cube = fx_mul(sq, vel, clipped);
			lin_term = fx_mul(a_gain, vel, clipped);
			cub_term = fx_mul(b_gain, cube, clipped);
			spring = fx_mul(it.stiffness, pos, clipped);
			lin_less_cub = fx_sub(lin_term, cub_term, clipped);
			accel = fx_sub(lin_less_cub, spring, clipped);
			dx = fx_mul(dt, vel, clipped);
			dv = fx_mul(dt, accel, clipped);
			pos = fx_add(pos, dx, clipped);
			vel = fx_add(vel, dv, clipped);
		end
		res.end_position = pos;
		res.end_velocity = vel;
		res.overflow = clipped;
		return res;
	endfunction

	// result checker: every strobe is matched against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_endpoints.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: pos %0d vel %0d ovf %0b",
						result.end_position, result.end_velocity, result.overflow);
			end else begin
				want = pending_endpoints.pop_front();
				if (result.end_position !== want.end_position ||
						result.end_velocity !== want.end_velocity ||
						result.overflow !== want.overflow) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"end point mismatch: exp pos %0d vel %0d ovf %0b,",
							" got pos %0d vel %0d ovf %0b"},
							want.end_position, want.end_velocity, want.overflow,
							result.end_position, result.end_velocity, result.overflow);
				end
			end
		end
	end

	function automatic item_t make_item(input logic signed [31:0] x, input logic signed [31:0] v,
			input logic [30:0] span, input logic signed [31:0] k);
		item_t it;
		it.start_position = x;
		it.start_velocity = v;
		it.time_span = span;
		it.stiffness = k;
		return it;
	endfunction

	// one item: hold start until the block takes it, then record the prediction
	task automatic send_item(input item_t it);
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy !== 1'b0);
		pending_endpoints.push_back(integrate_reed(it, linear_gain_model, cubic_gain_model));
	endtask

	// idle the sender for a number of cycles
	task automatic hold_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// stop sending and wait for every predicted end point
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_endpoints.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// leaves cfg_valid high so back to back writes need no extra toggle
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_LINEAR_GAIN)
			linear_gain_model = value;
		else if (idx == REG_CUBIC_GAIN)
			cubic_gain_model = value;
	endtask

	task automatic close_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_gains(input logic signed [31:0] a_gain, input logic signed [31:0] b_gain);
		write_register(REG_LINEAR_GAIN, a_gain);
		write_register(REG_CUBIC_GAIN, b_gain);
		close_writes();
	endtask

	// random item: mostly a settled oscillator, some moderate, some raw bits
	function automatic item_t random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return make_item(int'($urandom_range(0, 8 << Q_FRAC)) - (4 << Q_FRAC),
				int'($urandom_range(0, 4 << Q_FRAC)) - (2 << Q_FRAC),
				31'($urandom_range(0, 20 << Q_FRAC)),
				int'($urandom_range(0, 18 << Q_FRAC)) - (2 << Q_FRAC));
		if (sel < 85)
			return make_item(int'($urandom_range(0, 128 << Q_FRAC)) - (64 << Q_FRAC),
				int'($urandom_range(0, 128 << Q_FRAC)) - (64 << Q_FRAC),
				31'($urandom_range(0, 1 << 27)),
				int'($urandom_range(0, 512 << Q_FRAC)) - (256 << Q_FRAC));
		return make_item($urandom, $urandom, 31'($urandom), $urandom);
	endfunction

	function automatic logic signed [31:0] small_gain(input int span_units);
		return int'($urandom_range(0, (2 * span_units) << Q_FRAC)) - (span_units << Q_FRAC);
	endfunction

	// corner items at the reset gains
	task automatic test_reset_gains();
		send_item(make_item(0, 0, 0, 0));
		send_item(make_item(Q_MAX, Q_MAX, '1, Q_MAX));
		send_item(make_item(Q_MIN, Q_MIN, 0, Q_MIN));
		// span below the step count gives a zero step
		send_item(make_item(Q_ONE, 0, 31'(N_STEPS - 1), Q_ONE));
		// step of one lsb
		send_item(make_item(Q_ONE, Q_ONE / 2, 31'(N_STEPS), Q_ONE));
		// negative products round toward minus infinity
		send_item(make_item(-1, -1, 31'(N_STEPS * 1000), Q_ONE));
		send_item(make_item(Q_ONE, 0, 31'(10 * Q_ONE), Q_ONE));
		// negative stiffness
		send_item(make_item(Q_ONE / 2, Q_ONE / 4, 31'(5 * Q_ONE), -4 * Q_ONE));
		// cube of a large velocity clamps
		send_item(make_item(0, 100 * Q_ONE, 31'(Q_ONE), 0));
		// position update clamps high and low
		send_item(make_item(Q_MAX - 10, 1000 * Q_ONE, 31'(Q_ONE), 0));
		send_item(make_item(Q_MIN + 10, -1000 * Q_ONE, 31'(Q_ONE), 0));
		send_item(make_item(Q_ONE, 0, '1, Q_ONE));
		drain_results();
	endtask

	// gain registers at their extremes, and writes to unmapped indexes
	task automatic test_gain_registers();
		set_gains(Q_MAX, Q_MAX);
		send_item(make_item(Q_ONE, 0, 31'(10 * Q_ONE), Q_ONE));
		send_item(make_item(Q_ONE, Q_ONE / 2, 31'(N_STEPS), Q_ONE));
		drain_results();
		set_gains(Q_MIN, Q_MIN);
		send_item(make_item(Q_ONE, 0, 31'(10 * Q_ONE), Q_ONE));
		send_item(make_item(-1, -1, 31'(N_STEPS * 1000), Q_ONE));
		drain_results();
		set_gains(0, 0);
		send_item(make_item(Q_ONE, Q_ONE, 31'(10 * Q_ONE), Q_ONE));
		drain_results();
		set_gains(LINEAR_GAIN_RST, CUBIC_GAIN_RST);
		write_register(REG_UNMAPPED_TOP, 32'h0);
		write_register(CFG_IDX_W'($urandom_range(int'(REG_CUBIC_GAIN) + 1,
			(1 << CFG_IDX_W) - 1)), $urandom);
		close_writes();
		send_item(make_item(Q_ONE, 0, 31'(10 * Q_ONE), Q_ONE));
		send_item(make_item(Q_ONE / 2, -Q_ONE, 31'(8 * Q_ONE), 2 * Q_ONE));
		drain_results();
	endtask

	// bursts of items with short, long and no gaps, now and then a full drain
	task automatic run_bursts(input int count);
		int sent;
		int burst;
		int sel;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 8);
			for (int j = 0; j < burst && sent < count; j++) begin
				send_item(random_item());
				sent++;
			end
			sel = $urandom_range(0, 15);
			if (sel == 0)
				drain_results();
			else if (sel < 3)
				hold_sender($urandom_range(0, LONG_GAP));
			else if (sel < 6)
				hold_sender(0);
			else
				hold_sender($urandom_range(1, 20));
		end
	endtask

	// random traffic over several gain settings
	task automatic test_random_items();
		for (int phase = 0; phase < 6; phase++) begin
			drain_results();
			case (phase)
				0: set_gains(LINEAR_GAIN_RST, CUBIC_GAIN_RST);
				1: set_gains(small_gain(8), int'($urandom_range(0, 8 << Q_FRAC)));
				2: set_gains(Q_MAX, Q_MIN);
				3: set_gains($urandom, $urandom);
				4: set_gains(-2 * Q_ONE, 0);
				default: set_gains(small_gain(4), small_gain(4));
			endcase
			run_bursts(100);
		end
	endtask

	initial begin
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatch_count = 0;
		linear_gain_model = LINEAR_GAIN_RST;
		cubic_gain_model = CUBIC_GAIN_RST;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_gains();
		test_gain_registers();
		test_random_items();

		drain_results();
		repeat (ITEM_LATENCY + 16) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* files.f */
src/eroi_pkg.sv
src/eroi_front.sv
src/eroi_queue.sv
src/eroi_engine.sv
src/euler_reed_oscillator_integrator_unit.sv
bench/tb_top.sv
